@@ sv/pngenc_pkg.sv @@
`default_nettype none
package pngenc_pkg;

    // default size limits
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // field widths
    localparam int PIX_W = 24;
    localparam int CFG_W = 13;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [15:0] BLK_MAX   = 16'hFFFF;

    // command word from front to back
    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             open;
        logic             first;
        logic             close;
        logic [CFG_W:0]   w;
        logic [CFG_W:0]   h;
    } t_cmd;

    // reflected CRC-32 over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ sv/png_pix_if.sv @@
`default_nettype none
interface png_pix_if;
    import pngenc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_rgb;
    modport source (output valid, output pixel_rgb, input ready);
    modport sink (input valid, input pixel_rgb, output ready);
endinterface
`default_nettype wire

@@ sv/png_byte_if.sv @@
`default_nettype none
interface png_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       file_end;
    modport source (output valid, output out_byte, output file_end, input ready);
    modport sink (input valid, input out_byte, input file_end, output ready);
endinterface
`default_nettype wire

@@ sv/png_stored_deflate_encoder.sv @@
// PNG encoder, stored deflate, 8-bit RGBA output.
// i_pix carries one RGB pixel per word in raster order; o_byte carries the
// PNG file one byte per word, file_end set on the last IEND byte.
// Image size comes from the config port (index 0 width, 1 height), clamped to
// 1..MAX_WIDTH / 1..MAX_HEIGHT and latched on the first pixel of an image.
// Throughput: one output byte per cycle unless the receiver stalls or the queue
// runs empty. A pixel takes 4 bytes, 5 at a row start, plus 5 per stored block
// header; the first pixel adds 43 header bytes, the last 20 trailer bytes.
// The output byte rate sets the pixel rate.
// A two-word queue lets the front take pixels while the byte sequencer works.
// After a one-pixel image the next pixel is dropped; the one after opens a
// new file. A stalled receiver holds the output register; the sequencer and
// then the queue fill and i_pix.ready drops. Synchronous reset clears the
// sequencer, queue and counters; size registers reset to 1.
`default_nettype none
module png_stored_deflate_encoder
    import pngenc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire  [CFG_W-1:0] i_cfg_data,
    png_pix_if.sink          i_pix,
    png_byte_if.source       o_byte
);
    t_cmd q_in, q_out;
    logic q_push, q_pop, q_full, q_empty;

    pngenc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_pix.valid),
        .o_ready    (i_pix.ready),
        .i_pixel    (i_pix.pixel_rgb),
        .o_push     (q_push),
        .o_cmd      (q_in),
        .i_full     (q_full)
    );

    pngenc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    pngenc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_out),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_byte.valid),
        .i_ready (o_byte.ready),
        .o_byte  (o_byte.out_byte),
        .o_end   (o_byte.file_end)
    );

    // queue is never read empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty)) else $error("queue underflow");

    // queue is never written full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full)) else $error("queue overflow");

    // a stalled output word holds until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && !o_byte.ready) |=> (o_byte.valid
        && $stable(o_byte.out_byte) && $stable(o_byte.file_end)))
        else $error("output word changed under stall");
endmodule
`default_nettype wire

@@ sv/pngenc_queue.sv @@
`default_nettype none
module pngenc_queue
    import pngenc_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  wire  i_pop,
    output t_cmd o_data,
    output logic o_empty
);
    // two-word queue, head in slot 0
    t_cmd       r_slot [2];
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_slot[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // payload shift
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_slot[0] <= r_slot[1];
            if (i_push && r_cnt == 2'd1) r_slot[0] <= i_data;
            if (i_push && r_cnt == 2'd2) r_slot[1] <= i_data;
        end else if (i_push) begin
            if (r_cnt == 2'd0) r_slot[0] <= i_data;
            else r_slot[1] <= i_data;
        end
    end
endmodule
`default_nettype wire

@@ sv/pngenc_front.sv @@
`default_nettype none
module pngenc_front
    import pngenc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire  [CFG_W-1:0] i_cfg_data,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [PIX_W-1:0] i_pixel,
    output logic             o_push,
    output t_cmd             o_cmd,
    input  wire              i_full
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [WW-1:0]    r_col, r_lat_w, n_col, w_eff;
    logic [HW-1:0]    r_row, r_lat_h, n_row, h_eff;
    logic             r_active, r_skip;
    logic             acc, open, row_end, img_end;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W'(1);
            r_cfg_h <= CFG_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WIDTH) r_cfg_w <= i_cfg_data;
            if (i_cfg_idx == REG_HEIGHT) r_cfg_h <= i_cfg_data;
        end
    end

    // size clamp at image open
    always_comb begin
        w_eff = r_lat_w;
        h_eff = r_lat_h;
        if (!r_active) begin
            if (r_cfg_w == '0) w_eff = WW'(1);
            else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
            else w_eff = WW'(r_cfg_w);
            if (r_cfg_h == '0) h_eff = HW'(1);
            else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
            else h_eff = HW'(r_cfg_h);
        end
    end

    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready;
    assign open    = !r_active;
    assign n_col   = r_col + WW'(1);
    assign n_row   = r_row + HW'(1);
    assign row_end = (n_col >= w_eff);
    assign img_end = row_end && (n_row >= h_eff);

    // classify the word
    assign o_push      = acc && !r_skip;
    assign o_cmd.px    = i_pixel;
    assign o_cmd.open  = open;
    assign o_cmd.first = (r_col == '0);
    assign o_cmd.close = img_end;
    assign o_cmd.w     = (CFG_W + 1)'(w_eff);
    assign o_cmd.h     = (CFG_W + 1)'(h_eff);

    // position tracking; a one-pixel image eats the following pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_active <= 1'b0;
            r_skip   <= 1'b0;
            r_lat_w  <= WW'(1);
            r_lat_h  <= HW'(1);
        end else if (acc) begin
            if (r_skip) begin
                r_skip <= 1'b0;
            end else begin
                r_lat_w <= w_eff;
                r_lat_h <= h_eff;
                if (img_end) begin
                    r_col    <= '0;
                    r_row    <= '0;
                    r_active <= 1'b0;
                    r_skip   <= open;
                end else if (row_end) begin
                    r_col    <= '0;
                    r_row    <= n_row;
                    r_active <= 1'b1;
                end else begin
                    r_col    <= n_col;
                    r_active <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ sv/pngenc_back.sv @@
`default_nettype none
module pngenc_back
    import pngenc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cmd       i_cmd,
    input  wire        i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [7:0] o_byte,
    output logic       o_end
);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RAW_W = (WW + HW + 2 > 17) ? WW + HW + 2 : 17;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_BLK  = 3'd2;
    localparam logic [2:0] PH_DAT  = 3'd3;
    localparam logic [2:0] PH_TAIL = 3'd4;

    logic [2:0]       r_ph, n_ph;
    logic [5:0]       r_idx, n_idx;
    logic [2:0]       r_sub, n_sub;
    t_cmd             r_cur, n_cur;
    logic [RAW_W-1:0] r_raw, n_raw;
    logic [15:0]      r_blk, n_blk, r_nblk, blk_len, q0;
    logic [31:0]      r_crc, n_crc, r_idat, w32, h32, crc_x, adler, x32;
    logic [16:0]      rem, lo_sum, hi_sum;
    logic [15:0]      r_alo, n_alo, r_ahi, n_ahi, lo_mod;
    logic             r_ov, r_oe;
    logic [7:0]       r_ob, byt;
    logic             fire, use_crc, done, is_end;

    assign w32   = 32'(r_cur.w);
    assign h32   = 32'(r_cur.h);
    assign crc_x = r_crc ^ CRC_INIT;
    assign adler = {r_ahi, r_alo};
    assign blk_len = (r_raw > RAW_W'(BLK_MAX)) ? BLK_MAX : r_raw[15:0];

    // block count and IDAT length, settled during the signature bytes
    assign x32 = 32'(r_raw) + 32'd65534;
    assign q0  = x32[31:16];
    assign rem = {1'b0, x32[15:0]} + {1'b0, q0};
    always_ff @(posedge i_clk) begin
        r_nblk <= q0 + 16'(rem >= 17'd65535);
        r_idat <= 32'(r_raw) + 32'(r_nblk) * 32'd5 + 32'd6;
    end

    // byte selection
    always_comb begin
        byt     = 8'd0;
        use_crc = 1'b0;
        is_end  = 1'b0;
        case (r_ph)
            PH_HDR: begin
                use_crc = 1'b1;
                case (r_idx)
                    6'd0: begin byt = 8'd137; use_crc = 1'b0; end
                    6'd1: begin byt = 8'd80;  use_crc = 1'b0; end
                    6'd2: begin byt = 8'd78;  use_crc = 1'b0; end
                    6'd3: begin byt = 8'd71;  use_crc = 1'b0; end
                    6'd4: begin byt = 8'd13;  use_crc = 1'b0; end
                    6'd5: begin byt = 8'd10;  use_crc = 1'b0; end
                    6'd6: begin byt = 8'd26;  use_crc = 1'b0; end
                    6'd7: begin byt = 8'd10;  use_crc = 1'b0; end
                    6'd8, 6'd9, 6'd10: begin byt = 8'd0; use_crc = 1'b0; end
                    6'd11: begin byt = 8'd13; use_crc = 1'b0; end
                    6'd12: byt = 8'h49;
                    6'd13: byt = 8'h48;
                    6'd14: byt = 8'h44;
                    6'd15: byt = 8'h52;
                    6'd16: byt = w32[31:24];
                    6'd17: byt = w32[23:16];
                    6'd18: byt = w32[15:8];
                    6'd19: byt = w32[7:0];
                    6'd20: byt = h32[31:24];
                    6'd21: byt = h32[23:16];
                    6'd22: byt = h32[15:8];
                    6'd23: byt = h32[7:0];
                    6'd24: byt = 8'd8;
                    6'd25: byt = 8'd6;
                    6'd26, 6'd27, 6'd28: byt = 8'd0;
                    6'd29: begin byt = crc_x[31:24]; use_crc = 1'b0; end
                    6'd30: begin byt = crc_x[23:16]; use_crc = 1'b0; end
                    6'd31: begin byt = crc_x[15:8];  use_crc = 1'b0; end
                    6'd32: begin byt = crc_x[7:0];   use_crc = 1'b0; end
                    6'd33: begin byt = r_idat[31:24]; use_crc = 1'b0; end
                    6'd34: begin byt = r_idat[23:16]; use_crc = 1'b0; end
                    6'd35: begin byt = r_idat[15:8];  use_crc = 1'b0; end
                    6'd36: begin byt = r_idat[7:0];   use_crc = 1'b0; end
                    6'd37: byt = 8'h49;
                    6'd38: byt = 8'h44;
                    6'd39: byt = 8'h41;
                    6'd40: byt = 8'h54;
                    6'd41: byt = 8'h78;
                    default: byt = 8'h01;
                endcase
            end
            PH_BLK: begin
                use_crc = 1'b1;
                case (r_idx[2:0])
                    3'd0: byt = (RAW_W'(blk_len) == r_raw) ? 8'h01 : 8'h00;
                    3'd1: byt = blk_len[7:0];
                    3'd2: byt = blk_len[15:8];
                    3'd3: byt = ~blk_len[7:0];
                    default: byt = ~blk_len[15:8];
                endcase
            end
            PH_DAT: begin
                use_crc = 1'b1;
                case (r_sub)
                    3'd0: byt = 8'h00;
                    3'd1: byt = r_cur.px[23:16];
                    3'd2: byt = r_cur.px[15:8];
                    3'd3: byt = r_cur.px[7:0];
                    default: byt = 8'hFF;
                endcase
            end
            PH_TAIL: begin
                case (r_idx)
                    6'd0: begin byt = adler[31:24]; use_crc = 1'b1; end
                    6'd1: begin byt = adler[23:16]; use_crc = 1'b1; end
                    6'd2: begin byt = adler[15:8];  use_crc = 1'b1; end
                    6'd3: begin byt = adler[7:0];   use_crc = 1'b1; end
                    6'd4, 6'd16: byt = crc_x[31:24];
                    6'd5, 6'd17: byt = crc_x[23:16];
                    6'd6, 6'd18: byt = crc_x[15:8];
                    6'd7: byt = crc_x[7:0];
                    6'd12: begin byt = 8'h49; use_crc = 1'b1; end
                    6'd13: begin byt = 8'h45; use_crc = 1'b1; end
                    6'd14: begin byt = 8'h4E; use_crc = 1'b1; end
                    6'd15: begin byt = 8'h44; use_crc = 1'b1; end
                    6'd19: begin byt = crc_x[7:0]; is_end = 1'b1; end
                    default: byt = 8'h00;
                endcase
            end
            default: byt = 8'h00;
        endcase
    end

    // Adler-32 step, one compare-subtract per half
    assign lo_sum = {1'b0, r_alo} + {9'd0, byt};
    assign lo_mod = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    assign hi_sum = {1'b0, r_ahi} + {1'b0, lo_mod};

    assign fire = (r_ph != PH_IDLE) && (!r_ov || i_ready);

    // sequencer
    always_comb begin
        n_ph  = r_ph;
        n_idx = r_idx;
        n_sub = r_sub;
        n_cur = r_cur;
        n_raw = r_raw;
        n_blk = r_blk;
        n_alo = r_alo;
        n_ahi = r_ahi;
        n_crc = r_crc;
        done  = 1'b0;
        o_pop = 1'b0;
        if (fire) begin
            if (use_crc) n_crc = crc_byte(r_crc, byt);
            n_idx = r_idx + 6'd1;
            case (r_ph)
                PH_HDR: begin
                    if (r_idx == 6'd11 || r_idx == 6'd36) n_crc = CRC_INIT;
                    if (r_idx == 6'd42) begin
                        n_ph  = PH_BLK;
                        n_idx = '0;
                        n_sub = r_cur.first ? 3'd0 : 3'd1;
                    end
                end
                PH_BLK: begin
                    if (r_idx == 6'd4) begin
                        n_blk = blk_len;
                        n_ph  = PH_DAT;
                    end
                end
                PH_DAT: begin
                    n_alo = lo_mod;
                    n_ahi = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
                    n_blk = r_blk - 16'd1;
                    n_raw = r_raw - RAW_W'(1);
                    n_idx = '0;
                    if (r_sub == 3'd4) begin
                        if (r_cur.close) n_ph = PH_TAIL;
                        else done = 1'b1;
                    end else begin
                        n_sub = r_sub + 3'd1;
                        n_ph  = (n_blk == '0) ? PH_BLK : PH_DAT;
                    end
                end
                PH_TAIL: begin
                    if (r_idx == 6'd11) n_crc = CRC_INIT;
                    if (r_idx == 6'd19) done = 1'b1;
                end
                default: ;
            endcase
        end
        if (r_ph == PH_IDLE) done = 1'b1;
        // next word straight after the last byte of this one
        if (done) begin
            n_ph = PH_IDLE;
            if (!i_empty) begin
                o_pop = 1'b1;
                n_cur = i_cmd;
                n_idx = '0;
                n_sub = i_cmd.first ? 3'd0 : 3'd1;
                if (i_cmd.open) begin
                    n_ph  = PH_HDR;
                    n_raw = RAW_W'((RAW_W'(i_cmd.w) * RAW_W'(4) + RAW_W'(1))
                                   * RAW_W'(i_cmd.h));
                    n_alo = 16'd1;
                    n_ahi = 16'd0;
                    n_blk = '0;
                end else begin
                    n_ph = (n_blk == '0) ? PH_BLK : PH_DAT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_IDLE;
            r_idx <= '0;
            r_sub <= '0;
            r_raw <= '0;
            r_blk <= '0;
            r_alo <= 16'd1;
            r_ahi <= 16'd0;
            r_crc <= CRC_INIT;
            r_ov  <= 1'b0;
        end else begin
            r_ph  <= n_ph;
            r_idx <= n_idx;
            r_sub <= n_sub;
            r_raw <= n_raw;
            r_blk <= n_blk;
            r_alo <= n_alo;
            r_ahi <= n_ahi;
            r_crc <= n_crc;
            if (fire) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (fire) begin
            r_ob <= byt;
            r_oe <= is_end;
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_end   = r_oe;
endmodule
`default_nettype wire
